[design/sig_pkg.sv]
// sig_pkg: shared types and constants of the sphere index generator
// no dependencies; used by every other file of the block except sig_in_if
`timescale 1ns / 1ps
`default_nettype none

package sig_pkg;

  localparam int MAX_RINGS    = 256;
  localparam int MAX_SEGMENTS = 256;
  localparam int INDEX_BITS   = 16;

  localparam int CFG_WIDTH      = 9;
  localparam int CFG_INDEX_BITS = 1;
  localparam int IDX_W          = 16;
  localparam int CNT_W          = 8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_RING_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEGMENT_COUNT = 1'b1;

  localparam logic [CFG_WIDTH-1:0] RING_COUNT_RESET    = 9'd16;
  localparam logic [CFG_WIDTH-1:0] SEGMENT_COUNT_RESET = 9'd16;

  localparam logic [IDX_W-1:0] IDX_MASK =
    (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  typedef enum logic [1:0] {
    REG_TOP = 2'd0,
    REG_MID = 2'd1,
    REG_BOT = 2'd2
  } region_t;

  typedef struct packed {
    region_t          region;
    logic [CNT_W-1:0] band;
    logic [CNT_W-1:0] segment;
    logic             second_half;
  } pos_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic             last_triangle;
  } triangle_t;

endpackage

`default_nettype wire

[design/sig_in_if.sv]
// sig_in_if: input channel of the sphere index generator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface sig_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

[design/sig_out_if.sv]
// sig_out_if: triangle result channel of the sphere index generator
// depends on sig_pkg for the index width
`timescale 1ns / 1ps
`default_nettype none

interface sig_out_if;
  import sig_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index_a;
  logic [IDX_W-1:0] index_b;
  logic [IDX_W-1:0] index_c;
  logic             last_triangle;

  modport source (output valid, output index_a, output index_b, output index_c,
                  output last_triangle, input ready);
  modport sink (input valid, input index_a, input index_b, input index_c,
                input last_triangle, output ready);
endinterface

`default_nettype wire

[design/sig_step.sv]
// sig_step: one walk step over the sphere mesh, triangle indices and next position
// depends on sig_pkg for the position and triangle types
`timescale 1ns / 1ps
`default_nettype none

module sig_step
  import sig_pkg::*;
(
  input  pos_t                 pos_cur,
  input  logic                 restart,
  input  logic [CFG_WIDTH-1:0] ring_count,
  input  logic [CFG_WIDTH-1:0] segment_count,
  output pos_t                 pos_nxt,
  output triangle_t            result
);

  localparam logic [CFG_WIDTH-1:0] RING_HI = CFG_WIDTH'(MAX_RINGS);
  localparam logic [CFG_WIDTH-1:0] SEG_HI  = CFG_WIDTH'(MAX_SEGMENTS);
  localparam logic [CFG_WIDTH-1:0] MIN_CNT = CFG_WIDTH'(3);
  localparam int PW = CNT_W + CFG_WIDTH;

  logic [CFG_WIDTH-1:0] v_cnt;
  logic [CFG_WIDTH-1:0] h_cnt;
  logic [CFG_WIDTH-1:0] bands;
  logic [CFG_WIDTH-1:0] seg9;
  logic [CFG_WIDTH-1:0] band_inc;
  logic [CFG_WIDTH-1:0] v_minus2;
  logic                 region_ok;
  logic                 stale;
  logic                 seg_last;
  pos_t                 cur;
  logic [CNT_W-1:0]     mult_a;
  logic [PW-1:0]        product;
  logic [PW-1:0]        base;
  logic [PW-1:0]        j_idx;
  logic [PW-1:0]        jn_idx;
  logic [PW-1:0]        i_idx;
  logic [PW-1:0]        in_idx;
  logic [PW-1:0]        k_idx;
  logic [PW-1:0]        a_full;
  logic [PW-1:0]        b_full;
  logic [PW-1:0]        c_full;
  logic                 last;

  // saturate the registers into their legal range
  always_comb begin
    if (ring_count < MIN_CNT) v_cnt = MIN_CNT;
    else if (ring_count > RING_HI) v_cnt = RING_HI;
    else v_cnt = ring_count;
    if (segment_count < MIN_CNT) h_cnt = MIN_CNT;
    else if (segment_count > SEG_HI) h_cnt = SEG_HI;
    else h_cnt = segment_count;
  end

  assign bands    = v_cnt - CFG_WIDTH'(3);
  assign v_minus2 = v_cnt - CFG_WIDTH'(2);

  assign region_ok = (pos_cur.region == REG_TOP) || (pos_cur.region == REG_MID) ||
                     (pos_cur.region == REG_BOT);
  assign stale = restart || !region_ok ||
                 ({1'b0, pos_cur.segment} >= h_cnt) ||
                 ((pos_cur.region == REG_MID) && ({1'b0, pos_cur.band} >= bands));

  always_comb begin
    if (stale) begin
      cur.region      = REG_TOP;
      cur.band        = '0;
      cur.segment     = '0;
      cur.second_half = 1'b0;
    end else begin
      cur = pos_cur;
    end
  end

  assign seg9     = {1'b0, cur.segment};
  assign seg_last = (seg9 == h_cnt - CFG_WIDTH'(1));
  assign band_inc = {1'b0, cur.band} + CFG_WIDTH'(1);

  // one shared multiplier: ring base in the bands, pole index in the bottom fan
  assign mult_a  = (cur.region == REG_BOT) ? v_minus2[CNT_W-1:0] : cur.band;
  assign product = PW'(mult_a) * PW'(h_cnt);
  assign base    = product + PW'(1);
  assign j_idx   = base + PW'(seg9);
  assign jn_idx  = seg_last ? base : j_idx + PW'(1);
  assign i_idx   = j_idx + PW'(h_cnt);
  assign in_idx  = jn_idx + PW'(h_cnt);
  assign k_idx   = base - PW'(1) - PW'(seg9);

  always_comb begin
    pos_nxt = cur;
    last    = 1'b0;
    a_full  = '0;
    b_full  = '0;
    c_full  = '0;
    case (cur.region)
      REG_TOP: begin
        a_full = '0;
        b_full = PW'(seg9) + PW'(1);
        c_full = seg_last ? PW'(1) : PW'(seg9) + PW'(2);
        if (seg_last) begin
          pos_nxt.segment     = '0;
          pos_nxt.band        = '0;
          pos_nxt.second_half = 1'b0;
          pos_nxt.region      = (bands != '0) ? REG_MID : REG_BOT;
        end else begin
          pos_nxt.segment = cur.segment + CNT_W'(1);
        end
      end
      REG_MID: begin
        a_full = j_idx;
        if (!cur.second_half) begin
          b_full              = i_idx;
          c_full              = in_idx;
          pos_nxt.second_half = 1'b1;
        end else begin
          b_full              = in_idx;
          c_full              = jn_idx;
          pos_nxt.second_half = 1'b0;
          if (seg_last) begin
            pos_nxt.segment = '0;
            if (band_inc >= bands) begin
              pos_nxt.band   = '0;
              pos_nxt.region = REG_BOT;
            end else begin
              pos_nxt.band = band_inc[CNT_W-1:0];
            end
          end else begin
            pos_nxt.segment = cur.segment + CNT_W'(1);
          end
        end
      end
      default: begin
        a_full = base;
        b_full = k_idx;
        c_full = seg_last ? base - PW'(1) : k_idx - PW'(1);
        if (seg_last) begin
          last                = 1'b1;
          pos_nxt.region      = REG_TOP;
          pos_nxt.band        = '0;
          pos_nxt.segment     = '0;
          pos_nxt.second_half = 1'b0;
        end else begin
          pos_nxt.segment = cur.segment + CNT_W'(1);
        end
      end
    endcase
  end

  assign result.index_a       = a_full[IDX_W-1:0] & IDX_MASK;
  assign result.index_b       = b_full[IDX_W-1:0] & IDX_MASK;
  assign result.index_c       = c_full[IDX_W-1:0] & IDX_MASK;
  assign result.last_triangle = last;

endmodule

`default_nettype wire

[design/sphere_index_generator.sv]
// sphere_index_generator: top level, configuration, walk position and result register
// depends on sig_pkg, sig_in_if, sig_out_if and sig_step
//
// usage:
//   in_bus carries one request beat per triangle: restart = 1 begins again at the
//   first top fan triangle, restart = 0 moves on to the next triangle of the mesh.
//   out_bus returns one beat per request with the three vertex indices and
//   last_triangle, which is high on the final bottom fan triangle; after it the
//   walk wraps to the top fan.
//   cfg_we/cfg_index/cfg_data write ring_count (index 0) or segment_count
//   (index 1); write only while no request is in flight.
// result timing and rate:
//   a result appears in the cycle after its request beat is taken; one triangle per
//   cycle is sustained while out_bus is ready, set by the single step unit (one 8x9
//   multiplier and the index adders) between walk position and result register.
// reset:
//   rst_n low clears the result valid flag, sets both counts to 16 and the walk to
//   the first top fan triangle.
// stall:
//   while out_bus is stalled the result holds; a new request is taken in the same
//   cycle the held result leaves.
`timescale 1ns / 1ps
`default_nettype none

module sphere_index_generator
  import sig_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  sig_in_if.sink                    in_bus,
  sig_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]      cfg_data
);

  logic [CFG_WIDTH-1:0] ring_count_r;
  logic [CFG_WIDTH-1:0] segment_count_r;
  pos_t                 pos_r;
  pos_t                 pos_nxt;
  triangle_t            result_nxt;
  triangle_t            result_r;
  logic                 out_valid_r;
  logic                 in_ready;
  logic                 in_acc;

  sig_step u_step (
    .pos_cur       (pos_r),
    .restart       (in_bus.restart),
    .ring_count    (ring_count_r),
    .segment_count (segment_count_r),
    .pos_nxt       (pos_nxt),
    .result        (result_nxt)
  );

  assign in_ready     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = in_ready;
  assign in_acc       = in_bus.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r    <= RING_COUNT_RESET;
      segment_count_r <= SEGMENT_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RING_COUNT:    ring_count_r    <= cfg_data;
        CFG_SEGMENT_COUNT: segment_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r.region      <= REG_TOP;
      pos_r.band        <= '0;
      pos_r.segment     <= '0;
      pos_r.second_half <= 1'b0;
      out_valid_r       <= 1'b0;
    end else if (in_acc) begin
      pos_r       <= pos_nxt;
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      result_r <= result_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.index_a       = result_r.index_a;
  assign out_bus.index_b       = result_r.index_b;
  assign out_bus.index_c       = result_r.index_c;
  assign out_bus.last_triangle = result_r.last_triangle;

  // restart beat yields the first top fan triangle
  a_restart_top: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bus.restart) |=>
      (out_bus.valid && (out_bus.index_a == '0) && !out_bus.last_triangle))
    else $error("restart did not produce the first top fan triangle");

  // final triangle wraps the walk to the top fan
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && result_nxt.last_triangle) |=>
      ((pos_r.region == REG_TOP) && (pos_r.segment == '0)))
    else $error("walk did not wrap after the final triangle");

  // second half of a quad exists only inside the middle bands
  a_half_in_mid: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r.second_half |-> (pos_r.region == REG_MID))
    else $error("second half flag outside the middle bands");

  // every accepted beat leaves a result waiting
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking bench for sphere_index_generator, random request and stall bursts
// depends on sig_pkg, sig_in_if, sig_out_if and sphere_index_generator; a scoreboard predicts each triangle beat
`timescale 1ns / 1ps

module tb_top;
  import sig_pkg::*;

  localparam int ITEMS       = 1550;
  localparam int QUIET_AFTER = 1350;
  localparam int CYCLE_LIMIT = 400000;

  class triangle_scoreboard;
    logic [CFG_WIDTH-1:0] ring_count;
    logic [CFG_WIDTH-1:0] segment_count;
    region_t              region;
    int unsigned          band;
    int unsigned          segment;
    bit                   second_half;
    triangle_t            triangle_q[$];
    int                   errors;

    function new();
      ring_count    = RING_COUNT_RESET;
      segment_count = SEGMENT_COUNT_RESET;
      region        = REG_TOP;
      band          = 0;
      segment       = 0;
      second_half   = 0;
      errors        = 0;
    endfunction

    function void set_count(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_WIDTH-1:0] data);
      if (idx == CFG_RING_COUNT) begin
        ring_count = data;
      end else if (idx == CFG_SEGMENT_COUNT) begin
        segment_count = data;
      end
    endfunction

    function int unsigned clamp_count(logic [CFG_WIDTH-1:0] raw, int unsigned hi);
      int unsigned r;
      r = 32'(raw);
      if (r < 3) return 3;
      if (r > hi) return hi;
      return r;
    endfunction

    function void note_request(logic restart);
      int unsigned v, h, bands, base, j, jn, i, inx, pole, k;
      int unsigned a, b, c;
      bit          last;
      triangle_t   t;
      v     = clamp_count(ring_count, MAX_RINGS);
      h     = clamp_count(segment_count, MAX_SEGMENTS);
      bands = v - 3;
      last  = 0;
      // restart, or a position left stale by a count change
      if (restart || segment >= h || (region == REG_MID && band >= bands)) begin
        region      = REG_TOP;
        band        = 0;
        segment     = 0;
        second_half = 0;
      end
      case (region)
        REG_TOP: begin
          a = 0;
          b = segment + 1;
          c = (segment == h - 1) ? 1 : segment + 2;
          segment++;
          if (segment >= h) begin
            segment     = 0;
            band        = 0;
            second_half = 0;
            region      = (bands > 0) ? REG_MID : REG_BOT;
          end
        end
        REG_MID: begin
          base = band * h + 1;
          j    = base + segment;
          jn   = (segment == h - 1) ? base : j + 1;
          i    = j + h;
          inx  = jn + h;
          a    = j;
          if (!second_half) begin
            b           = i;
            c           = inx;
            second_half = 1;
          end else begin
            b           = inx;
            c           = jn;
            second_half = 0;
            segment++;
            if (segment >= h) begin
              segment = 0;
              band++;
              if (band >= bands) begin
                band   = 0;
                region = REG_BOT;
              end
            end
          end
        end
        default: begin
          pole = (v - 2) * h + 1;
          k    = pole - 1 - segment;
          a    = pole;
          b    = k;
          c    = (segment == h - 1) ? pole - 1 : k - 1;
          segment++;
          if (segment >= h) begin
            last        = 1;
            segment     = 0;
            band        = 0;
            second_half = 0;
            region      = REG_TOP;
          end
        end
      endcase
      t.index_a       = IDX_W'(a) & IDX_MASK;
      t.index_b       = IDX_W'(b) & IDX_MASK;
      t.index_c       = IDX_W'(c) & IDX_MASK;
      t.last_triangle = last;
      triangle_q.push_back(t);
    endfunction

    function void check_triangle(triangle_t got);
      triangle_t want;
      if (triangle_q.size() == 0) begin
        $error("triangle beat with none pending: a=%0d b=%0d c=%0d last=%0d",
               got.index_a, got.index_b, got.index_c, got.last_triangle);
        errors++;
        return;
      end
      want = triangle_q.pop_front();
      if (got.index_a !== want.index_a) begin
        $error("index_a expected %0d actual %0d", want.index_a, got.index_a);
        errors++;
      end
      if (got.index_b !== want.index_b) begin
        $error("index_b expected %0d actual %0d", want.index_b, got.index_b);
        errors++;
      end
      if (got.index_c !== want.index_c) begin
        $error("index_c expected %0d actual %0d", want.index_c, got.index_c);
        errors++;
      end
      if (got.last_triangle !== want.last_triangle) begin
        $error("last_triangle expected %0d actual %0d", want.last_triangle, got.last_triangle);
        errors++;
      end
    endfunction

    function int outstanding();
      return triangle_q.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]      cfg_data;

  sig_in_if  in_if ();
  sig_out_if out_if ();

  sphere_index_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_if),
    .out_bus   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  triangle_scoreboard sb = new();
  int        sent;
  int        src_pct;
  bit        quiet;
  int        cycles;
  triangle_t seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen.index_a       = out_if.index_a;
        seen.index_b       = out_if.index_b;
        seen.index_c       = out_if.index_c;
        seen.last_triangle = out_if.last_triangle;
        sb.check_triangle(seen);
      end
      if (in_if.valid && in_if.ready) sb.note_request(in_if.restart);
    end
  end

  // result side stall bursts
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_WIDTH-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_count(idx, data);
  endtask

  task automatic set_counts(bit wr_ring, bit wr_seg,
                            logic [CFG_WIDTH-1:0] rings, logic [CFG_WIDTH-1:0] segs);
    if (wr_ring) cfg_write(CFG_RING_COUNT, rings);
    if (wr_seg) cfg_write(CFG_SEGMENT_COUNT, segs);
    if (wr_ring || wr_seg) begin
      @(posedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic send_request(logic restart);
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    quiet = (sent >= QUIET_AFTER);
    if (!quiet && src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [CFG_WIDTH-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return CFG_WIDTH'($urandom_range(3, 8));
      6: return CFG_WIDTH'($urandom_range(9, 40));
      7: begin
        case ($urandom_range(0, 6))
          0: return 9'd0;
          1: return 9'd1;
          2: return 9'd2;
          3: return 9'd3;
          4: return 9'd256;
          5: return 9'd257;
          default: return 9'd511;
        endcase
      end
      default: return CFG_WIDTH'($urandom_range(0, 511));
    endcase
  endfunction

  initial begin
    int n;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_RING_COUNT;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    sent          = 0;
    src_pct       = 0;
    quiet         = 0;
    cycles        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // default 16 x 16 mesh
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    // three rings: top fan straight into bottom fan, last flag and wrap
    wait_idle();
    set_counts(1'b1, 1'b1, 9'd3, 9'd3);
    repeat (7) send_request(1'b0);
    // one middle band, reached after the top fan seam
    wait_idle();
    set_counts(1'b1, 1'b1, 9'd4, 9'd3);
    repeat (6) send_request(1'b0);
    // middle band vanishes under the walk
    wait_idle();
    set_counts(1'b1, 1'b0, 9'd3, 9'd0);
    repeat (2) send_request(1'b0);
    // saturated counts at both ends
    wait_idle();
    set_counts(1'b1, 1'b1, 9'd0, 9'd511);
    send_request(1'b1);
    send_request(1'b0);
    wait_idle();
    set_counts(1'b1, 1'b1, 9'd511, 9'd2);
    send_request(1'b0);
    send_request(1'b1);

    while (sent < ITEMS) begin
      wait_idle();
      set_counts($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                 pick_count(), pick_count());
      case ($urandom_range(0, 2))
        0: src_pct = 0;
        1: src_pct = 10;
        default: src_pct = 40;
      endcase
      n = $urandom_range(10, 120);
      for (int k = 0; k < n; k++) begin
        if (k == 0) send_request(1'($urandom_range(0, 1)));
        else send_request($urandom_range(0, 24) == 0);
      end
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
